/* src/svfm_pkg.sv */
// ----------------------------------------------------------------------------
// svfm_pkg: shared types, widths and helpers of the morphing state variable
// filter.
// Holds the fixed-point widths, the register and operation codes, the
// control bundle between sequencer and datapath, and the saturation helpers.
// ----------------------------------------------------------------------------
package svfm_pkg;

   localparam int SampleW = 24;   // Q1.23 audio sample
   localparam int StateW  = 32;   // integrator and internal response width
   localparam int GainW   = 29;   // unsigned Q5.24
   localparam int DampW   = 29;   // unsigned Q5.24
   localparam int NormW   = 25;   // unsigned Q1.24
   localparam int MorphW  = 17;   // unsigned Q1.16
   localparam int CoefW   = 30;   // gain plus damping, also the multiplier B width
   localparam int AmountW = 17;   // crossfade weight, 0 to 1.0 in Q1.16
   localparam int MulAW   = 33;   // signed multiplier A operand
   localparam int ProdW   = 64;   // full product
   localparam int RndW    = 48;   // rounded product
   localparam int SumW    = 50;   // headroom for the adds before saturation
   localparam int AddrW   = 4;
   localparam int DataW   = 32;

   localparam logic [GainW-1:0]  GainReset  = '0;
   localparam logic [DampW-1:0]  DampReset  = 29'd16777216;
   localparam logic [NormW-1:0]  NormReset  = 25'd16777216;
   localparam logic [MorphW-1:0] MorphReset = '0;
   localparam logic [MorphW-1:0] MorphOne   = 17'd65536;
   localparam logic [MorphW-1:0] MorphHalf  = 17'd32768;

   typedef enum logic [1:0] {
      REG_CUTOFF_GAIN = 2'd0,
      REG_DAMPING     = 2'd1,
      REG_NORMALISER  = 2'd2,
      REG_MORPH       = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      OP_COEF = 3'd0,   // s1 * (g + r2)
      OP_NORM = 3'd1,   // diff * h
      OP_HIGH = 3'd2,   // high * g
      OP_BAND = 3'd3,   // band * g
      OP_MIX  = 3'd4    // response difference * crossfade weight
   } mul_op_type;

   typedef struct packed {
      logic [GainW-1:0]  gain;
      logic [DampW-1:0]  damping;
      logic [NormW-1:0]  norm;
      logic [MorphW-1:0] morph;
   } cfg_type;

   typedef struct packed {
      logic       take_req;
      logic       mul_go;
      mul_op_type mul_op;
      logic       ld_diff;
      logic       ld_high;
      logic       ld_band;
      logic       ld_s1;
      logic       ld_low;
      logic       ld_prep;
      logic       ld_result;
   } ctrl_type;

   function automatic logic signed [StateW-1:0] sat_to_32(input logic signed [SumW-1:0] v);
      logic signed [StateW-1:0] r;
      if (v[SumW-1:StateW-1] == {(SumW-StateW+1){v[SumW-1]}}) begin
         r = v[StateW-1:0];
      end else if (v[SumW-1]) begin
         r = {1'b1, {(StateW-1){1'b0}}};
      end else begin
         r = {1'b0, {(StateW-1){1'b1}}};
      end
      return r;
   endfunction

   function automatic logic signed [SampleW-1:0] sat_to_24(input logic signed [SumW-1:0] v);
      logic signed [SampleW-1:0] r;
      if (v[SumW-1:SampleW-1] == {(SumW-SampleW+1){v[SumW-1]}}) begin
         r = v[SampleW-1:0];
      end else if (v[SumW-1]) begin
         r = {1'b1, {(SampleW-1){1'b0}}};
      end else begin
         r = {1'b0, {(SampleW-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

/* src/svfm_mul_unit.sv */
// ----------------------------------------------------------------------------
// svfm_mul_unit: shared multiplier with round-to-nearest shift.
// Registers the signed product, then rounds it down by 24 or 16 bits
// (ties toward plus infinity) into a second register.
// ----------------------------------------------------------------------------
module svfm_mul_unit import svfm_pkg::*; (
   input  logic                      clock,
   input  logic                      mul_go,
   input  logic                      round16,
   input  logic signed [MulAW-1:0]   op_a,
   input  logic        [CoefW-1:0]   op_b,
   output logic signed [RndW-1:0]    rnd_out
);

   logic signed [ProdW-1:0] prod_in;
   logic signed [ProdW-1:0] prod_ff;
   logic                    round16_ff;
   logic signed [ProdW-1:0] half;
   logic signed [ProdW-1:0] sum;
   logic signed [RndW-1:0]  rnd_in;
   logic signed [RndW-1:0]  rnd_ff;

   assign prod_in = op_a * $signed({1'b0, op_b});

   always_comb begin
      half   = round16_ff ? 64'sd32768 : 64'sd8388608;
      sum    = prod_ff + half;
      rnd_in = round16_ff ? sum[ProdW-1:16] : RndW'($signed(sum[ProdW-1:24]));
   end

   always_ff @(posedge clock) begin
      if (mul_go) begin
         prod_ff    <= prod_in;
         round16_ff <= round16;
      end
      rnd_ff <= rnd_in;
   end

   assign rnd_out = rnd_ff;

endmodule

/* src/svfm_datapath.sv */
// ----------------------------------------------------------------------------
// svfm_datapath: filter state, intermediate responses and output registers.
// Selects the operands of the shared multiplier and folds each rounded
// product into the integrators and responses with saturation.
// ----------------------------------------------------------------------------
module svfm_datapath import svfm_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  ctrl_type                   ctrl,
   input  cfg_type                    cfg,
   input  logic signed [SampleW-1:0]  req_sample,
   input  logic signed [RndW-1:0]     rnd,
   output logic signed [MulAW-1:0]    op_a,
   output logic        [CoefW-1:0]    op_b,
   output logic                       round16,
   output logic signed [SampleW-1:0]  rsp_lowpass_out,
   output logic signed [SampleW-1:0]  rsp_bandpass_out,
   output logic signed [SampleW-1:0]  rsp_highpass_out,
   output logic signed [SampleW-1:0]  rsp_morphed_out
);

   logic signed [SampleW-1:0] x_ff;
   logic        [CoefW-1:0]   coef_ff;
   logic signed [StateW-1:0]  s1_ff, s1_in;
   logic signed [StateW-1:0]  s2_ff, s2_in;
   logic signed [StateW-1:0]  diff_ff, high_ff, band_ff, low_ff, mbase_ff;
   logic signed [MulAW-1:0]   mdiff_ff, mdiff_in;
   logic        [AmountW-1:0] amount_ff, amount_in;
   logic signed [StateW-1:0]  mbase_in;
   logic signed [SampleW-1:0] low_out_ff, band_out_ff, high_out_ff, mix_out_ff;

   logic signed [SumW-1:0]    rnd_w, x_w, s1_w, s2_w, band_w, low_w, mbase_w;
   logic        [MorphW-1:0]  morph_c;
   logic        [MorphW:0]    amount_wide;
   logic                      sel_high;

   always_comb begin
      rnd_w   = SumW'(rnd);
      x_w     = SumW'(x_ff);
      s1_w    = SumW'(s1_ff);
      s2_w    = SumW'(s2_ff);
      band_w  = SumW'(band_ff);
      low_w   = SumW'(low_ff);
      mbase_w = SumW'(mbase_ff);
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      round16 = 1'b0;
      case (ctrl.mul_op)
         OP_COEF: begin
            op_a = MulAW'(s1_ff);
            op_b = coef_ff;
         end
         OP_NORM: begin
            op_a = MulAW'(diff_ff);
            op_b = CoefW'(cfg.norm);
         end
         OP_HIGH: begin
            op_a = MulAW'(high_ff);
            op_b = CoefW'(cfg.gain);
         end
         OP_BAND: begin
            op_a = MulAW'(band_ff);
            op_b = CoefW'(cfg.gain);
         end
         OP_MIX: begin
            op_a    = mdiff_ff;
            op_b    = CoefW'(amount_ff);
            round16 = 1'b1;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // Crossfade setup: below one half blend low toward band, above it band toward high.
   always_comb begin
      morph_c     = (cfg.morph > MorphOne) ? MorphOne : cfg.morph;
      sel_high    = morph_c > MorphHalf;
      amount_wide = sel_high ? {morph_c - MorphHalf, 1'b0} : {morph_c, 1'b0};
      amount_in   = amount_wide[AmountW-1:0];
      if (sel_high) begin
         mdiff_in = MulAW'(high_ff) - MulAW'(band_ff);
         mbase_in = band_ff;
      end else begin
         mdiff_in = MulAW'(band_ff) - MulAW'(low_ff);
         mbase_in = low_ff;
      end
      s1_in = sat_to_32(rnd_w + band_w);
      s2_in = sat_to_32(rnd_w + low_w);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
         s2_ff <= '0;
      end else begin
         if (ctrl.ld_s1) begin
            s1_ff <= s1_in;
         end
         if (ctrl.ld_prep) begin
            s2_ff <= s2_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.take_req) begin
         x_ff    <= req_sample;
         coef_ff <= CoefW'(cfg.gain) + CoefW'(cfg.damping);
      end
      if (ctrl.ld_diff) begin
         diff_ff <= sat_to_32(x_w - rnd_w - s2_w);
      end
      if (ctrl.ld_high) begin
         high_ff <= sat_to_32(rnd_w);
      end
      if (ctrl.ld_band) begin
         band_ff <= sat_to_32(rnd_w + s1_w);
      end
      if (ctrl.ld_low) begin
         low_ff <= sat_to_32(rnd_w + s2_w);
      end
      if (ctrl.ld_prep) begin
         mdiff_ff  <= mdiff_in;
         mbase_ff  <= mbase_in;
         amount_ff <= amount_in;
      end
      if (ctrl.ld_result) begin
         low_out_ff  <= sat_to_24(low_w);
         band_out_ff <= sat_to_24(band_w);
         high_out_ff <= sat_to_24(SumW'(high_ff));
         mix_out_ff  <= sat_to_24(mbase_w + rnd_w);
      end
   end

   assign rsp_lowpass_out  = low_out_ff;
   assign rsp_bandpass_out = band_out_ff;
   assign rsp_highpass_out = high_out_ff;
   assign rsp_morphed_out  = mix_out_ff;

endmodule

/* src/svfm_ctrl.sv */
// ----------------------------------------------------------------------------
// svfm_ctrl: sequencer of the filter.
// Steps one request through five dependent multiplies on the shared unit
// and owns the request and response handshakes.
// ----------------------------------------------------------------------------
module svfm_ctrl import svfm_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output ctrl_type ctrl
);

   typedef enum logic [16:0] {
      ST_IDLE   = 17'h00001,
      ST_M_COEF = 17'h00002,
      ST_W_COEF = 17'h00004,
      ST_DIFF   = 17'h00008,
      ST_M_NORM = 17'h00010,
      ST_W_NORM = 17'h00020,
      ST_HIGH   = 17'h00040,
      ST_M_GH   = 17'h00080,
      ST_W_GH   = 17'h00100,
      ST_BAND   = 17'h00200,
      ST_M_GB   = 17'h00400,
      ST_W_GB   = 17'h00800,
      ST_LOW    = 17'h01000,
      ST_PREP   = 17'h02000,
      ST_M_MIX  = 17'h04000,
      ST_W_MIX  = 17'h08000,
      ST_DONE   = 17'h10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      ctrl         = '0;
      ctrl.mul_op  = OP_COEF;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctrl.take_req = 1'b1;
               state_in      = ST_M_COEF;
            end
         end
         ST_M_COEF: begin
            ctrl.mul_go = 1'b1;
            ctrl.mul_op = OP_COEF;
            state_in    = ST_W_COEF;
         end
         ST_W_COEF: state_in = ST_DIFF;
         ST_DIFF: begin
            ctrl.ld_diff = 1'b1;
            state_in     = ST_M_NORM;
         end
         ST_M_NORM: begin
            ctrl.mul_go = 1'b1;
            ctrl.mul_op = OP_NORM;
            state_in    = ST_W_NORM;
         end
         ST_W_NORM: state_in = ST_HIGH;
         ST_HIGH: begin
            ctrl.ld_high = 1'b1;
            state_in     = ST_M_GH;
         end
         ST_M_GH: begin
            ctrl.mul_go = 1'b1;
            ctrl.mul_op = OP_HIGH;
            state_in    = ST_W_GH;
         end
         ST_W_GH: state_in = ST_BAND;
         ST_BAND: begin
            ctrl.ld_band = 1'b1;
            state_in     = ST_M_GB;
         end
         ST_M_GB: begin
            // The product high*g is still in the rounding register here.
            ctrl.mul_go = 1'b1;
            ctrl.mul_op = OP_BAND;
            ctrl.ld_s1  = 1'b1;
            state_in    = ST_W_GB;
         end
         ST_W_GB: state_in = ST_LOW;
         ST_LOW: begin
            ctrl.ld_low = 1'b1;
            state_in    = ST_PREP;
         end
         ST_PREP: begin
            ctrl.ld_prep = 1'b1;
            state_in     = ST_M_MIX;
         end
         ST_M_MIX: begin
            ctrl.mul_go = 1'b1;
            ctrl.mul_op = OP_MIX;
            state_in    = ST_W_MIX;
         end
         ST_W_MIX: state_in = ST_DONE;
         ST_DONE: begin
            ctrl.mul_op = OP_MIX;
            if (!rsp_valid_ff || rsp_ready) begin
               ctrl.ld_result = 1'b1;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while a previous one was in flight");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside of the final step");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid && !rsp_ready) |=> (state_ff == ST_DONE && rsp_valid))
      else $error("pending response overwritten");

   a_mul_spacing: assert property (@(posedge clock) disable iff (reset)
      ctrl.mul_go |=> !ctrl.mul_go ##1 !ctrl.mul_go)
      else $error("multiplier reissued before its result was used");
`endif

endmodule

/* src/svf_morph_filter.sv */
// ----------------------------------------------------------------------------
// svf_morph_filter: trapezoidal state variable filter with response morph.
// Top level: configuration registers, sequencer, shared multiplier and
// datapath.
// ----------------------------------------------------------------------------
// Each request carries one signed Q1.23 sample and produces one response
// with the lowpass, bandpass, highpass and morphed outputs, all saturated to
// 24 bits. The filter is ready for the next request in the same cycle in
// which the response to the last one turns valid. It takes no new sample
// before it has finished the last one, and it holds a finished result
// until the previous response has been taken. The time per request is
// set by the five dependent multiplies that go through the one shared
// multiplier: each product is registered, then rounded into a second
// register, then folded into the filter state. The finished response sits
// in an output register, so a new request is taken while the previous
// response still waits for rsp_ready. The coefficients g, r2 and h and
// the morph amount are written through the APB-style port at byte
// addresses 0, 4, 8 and 12; software computes them, and they must only be
// changed while the filter is idle. The integrator states clear on reset.
// ----------------------------------------------------------------------------
module svf_morph_filter import svfm_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SampleW-1:0]  req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SampleW-1:0]  rsp_lowpass_out,
   output logic signed [SampleW-1:0]  rsp_bandpass_out,
   output logic signed [SampleW-1:0]  rsp_highpass_out,
   output logic signed [SampleW-1:0]  rsp_morphed_out,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic        [AddrW-1:0]    csr_paddr,
   input  logic        [DataW-1:0]    csr_pwdata,
   output logic        [DataW-1:0]    csr_prdata,
   output logic                       csr_pready
);

   cfg_type                 cfg_ff;
   ctrl_type                ctrl;
   csr_index_type           csr_index;
   logic                    csr_write;
   logic signed [MulAW-1:0] op_a;
   logic        [CoefW-1:0] op_b;
   logic                    round16;
   logic signed [RndW-1:0]  rnd;

   // The register slot is taken from the word address; byte offsets are ignored.
   assign csr_index  = csr_index_type'(csr_paddr[AddrW-1:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain    <= GainReset;
         cfg_ff.damping <= DampReset;
         cfg_ff.norm    <= NormReset;
         cfg_ff.morph   <= MorphReset;
      end else if (csr_write) begin
         case (csr_index)
            REG_CUTOFF_GAIN: cfg_ff.gain    <= csr_pwdata[GainW-1:0];
            REG_DAMPING:     cfg_ff.damping <= csr_pwdata[DampW-1:0];
            REG_NORMALISER:  cfg_ff.norm    <= csr_pwdata[NormW-1:0];
            REG_MORPH:       cfg_ff.morph   <= csr_pwdata[MorphW-1:0];
            default: ;
         endcase
      end
   end

   // Reads return the stored register, zero extended to the bus width.
   always_comb begin
      case (csr_index)
         REG_CUTOFF_GAIN: csr_prdata = DataW'(cfg_ff.gain);
         REG_DAMPING:     csr_prdata = DataW'(cfg_ff.damping);
         REG_NORMALISER:  csr_prdata = DataW'(cfg_ff.norm);
         REG_MORPH:       csr_prdata = DataW'(cfg_ff.morph);
         default:         csr_prdata = '0;
      endcase
   end

   // The sequencer walks each request through the multiply steps.
   svfm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctrl      (ctrl)
   );

   // One multiplier serves all five products, with rounding folded behind it.
   svfm_mul_unit u_mul (
      .clock   (clock),
      .mul_go  (ctrl.mul_go),
      .round16 (round16),
      .op_a    (op_a),
      .op_b    (op_b),
      .rnd_out (rnd)
   );

   // The datapath holds the integrators and assembles the four responses.
   svfm_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .cfg              (cfg_ff),
      .req_sample       (req_sample),
      .rnd              (rnd),
      .op_a             (op_a),
      .op_b             (op_b),
      .round16          (round16),
      .rsp_lowpass_out  (rsp_lowpass_out),
      .rsp_bandpass_out (rsp_bandpass_out),
      .rsp_highpass_out (rsp_highpass_out),
      .rsp_morphed_out  (rsp_morphed_out)
   );

endmodule

/* dv/tb_svf_morph_filter.sv */
// ----------------------------------------------------------------------------
// tb_svf_morph_filter: self-checking testbench of the morphing state variable
// filter.
// Requests are sent in random bursts while the response side stalls on its
// own pattern. Every accepted request is run through a bit-exact fixed-point
// copy of the filter kept here, and each response is checked field by field
// against the oldest prediction. Coefficients are programmed and read back
// over the APB-style port whenever the filter has gone idle.
// ----------------------------------------------------------------------------
module tb_svf_morph_filter;
   timeunit 1ns;
   timeprecision 1ps;

   import svfm_pkg::*;

   // One in Q.24, the scale of the gain, damping and normaliser registers.
   localparam longint QOne = 64'd16777216;
   // Cycles without any handshake before the run is declared hung. The slowest
   // legal stretch is a sender gap plus the computation plus the longest
   // receiver stall.
   localparam int WatchdogLimit = 2000;
   localparam int TailCycles    = 40;
   localparam int MaxGap        = 30;
   localparam int PhaseItems    = 50;
   localparam int RandomPhases  = 13;

   typedef struct packed {
      logic [SampleW-1:0] lowpass;
      logic [SampleW-1:0] bandpass;
      logic [SampleW-1:0] highpass;
      logic [SampleW-1:0] morphed;
   } filter_outputs_type;

   // Block ports. Every input starts at a known value.
   logic                      clock        = 1'b0;
   logic                      reset        = 1'b1;
   logic                      req_valid    = 1'b0;
   logic                      req_ready;
   logic signed [SampleW-1:0] req_sample   = '0;
   logic                      rsp_valid;
   logic                      rsp_ready    = 1'b0;
   logic signed [SampleW-1:0] rsp_lowpass_out;
   logic signed [SampleW-1:0] rsp_bandpass_out;
   logic signed [SampleW-1:0] rsp_highpass_out;
   logic signed [SampleW-1:0] rsp_morphed_out;
   logic                      csr_psel     = 1'b0;
   logic                      csr_penable  = 1'b0;
   logic                      csr_pwrite   = 1'b0;
   logic [AddrW-1:0]          csr_paddr    = '0;
   logic [DataW-1:0]          csr_pwdata   = '0;
   logic [DataW-1:0]          csr_prdata;
   logic                      csr_pready;

   // Our own copy of the coefficient registers and the two integrators,
   // starting from their reset values.
   logic [GainW-1:0]  gain_q  = GainReset;
   logic [DampW-1:0]  damp_q  = DampReset;
   logic [NormW-1:0]  norm_q  = NormReset;
   logic [MorphW-1:0] morph_q = MorphReset;
   longint            integ1  = 0;
   longint            integ2  = 0;

   // Filter outputs predicted for accepted requests, oldest first.
   filter_outputs_type outputs_due[$];

   int error_count = 0;
   int idle_cycles = 0;
   int burst_left  = 0;

   // Receiver stall pattern state.
   int ready_mode  = 0;
   int mode_left   = 100;
   int stall_left  = 0;

   svf_morph_filter dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_lowpass_out  (rsp_lowpass_out),
      .rsp_bandpass_out (rsp_bandpass_out),
      .rsp_highpass_out (rsp_highpass_out),
      .rsp_morphed_out  (rsp_morphed_out),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always #4 clock = ~clock;

   // ------------------------------------------------------------------------
   // Fixed-point filter arithmetic.
   // ------------------------------------------------------------------------

   // Clamps a value to the signed range of the given number of bits.
   function automatic longint clamp_to(input longint v, input int bits);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         return hi;
      end
      if (v < lo) begin
         return lo;
      end
      return v;
   endfunction

   // Divides by 2^s, rounding to nearest with ties going toward plus infinity.
   // Adding half and then shifting arithmetically is exactly a floor of the
   // biased value, which gives that rounding for both signs.
   function automatic longint round_shift_up(input longint v, input int s);
      longint r;
      r = v + (longint'(1) <<< (s - 1));
      return r >>> s;
   endfunction

   // Runs one sample through the filter, advances both integrators and
   // returns the four saturated outputs.
   function automatic filter_outputs_type filter_sample(
         input logic signed [SampleW-1:0] x_in);
      longint x, g, coef, h;
      longint diff, high, band, low, gh, gb, mix, m, amount;
      filter_outputs_type r;
      x    = longint'(x_in);
      g    = longint'(gain_q);
      coef = longint'(gain_q) + longint'(damp_q);
      h    = longint'(norm_q);

      diff   = clamp_to(x - round_shift_up(integ1 * coef, 24) - integ2, StateW);
      high   = clamp_to(round_shift_up(diff * h, 24), StateW);
      gh     = round_shift_up(high * g, 24);
      band   = clamp_to(gh + integ1, StateW);
      integ1 = clamp_to(gh + band, StateW);
      gb     = round_shift_up(band * g, 24);
      low    = clamp_to(gb + integ2, StateW);
      integ2 = clamp_to(gb + low, StateW);

      // A morph amount above one behaves as pure highpass.
      m = (morph_q > MorphOne) ? longint'(MorphOne) : longint'(morph_q);
      if (m <= longint'(MorphHalf)) begin
         amount = 2 * m;
         mix    = low + round_shift_up((band - low) * amount, 16);
      end else begin
         amount = 2 * (m - longint'(MorphHalf));
         mix    = band + round_shift_up((high - band) * amount, 16);
      end

      r.lowpass  = SampleW'(clamp_to(low, SampleW));
      r.bandpass = SampleW'(clamp_to(band, SampleW));
      r.highpass = SampleW'(clamp_to(high, SampleW));
      r.morphed  = SampleW'(clamp_to(mix, SampleW));
      return r;
   endfunction

   // Normaliser that goes with a gain and damping, as software would set it.
   function automatic longint norm_for(input longint g, input longint r2);
      longint denom;
      denom = QOne + ((r2 * g) >>> 24) + ((g * g) >>> 24);
      return (longint'(1) <<< 48) / denom;
   endfunction

   // ------------------------------------------------------------------------
   // Reporting and checking.
   // ------------------------------------------------------------------------

   task automatic report_error(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [SampleW-1:0] got,
                              input logic [SampleW-1:0] want);
      if (got !== want) begin
         report_error($sformatf("%s is %0d, expected %0d", name, $signed(got),
                                $signed(want)));
      end
   endtask

   // Sampled at the rising edge: predicts each accepted request, checks each
   // accepted response against the oldest prediction, and tracks how long
   // nothing has moved for the watchdog.
   always @(posedge clock) begin
      filter_outputs_type want;
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (outputs_due.size() == 0) begin
               report_error("response arrived with no request outstanding");
            end else begin
               want = outputs_due.pop_front();
               check_field("lowpass_out", rsp_lowpass_out, want.lowpass);
               check_field("bandpass_out", rsp_bandpass_out, want.bandpass);
               check_field("highpass_out", rsp_highpass_out, want.highpass);
               check_field("morphed_out", rsp_morphed_out, want.morphed);
            end
         end
         if (req_valid && req_ready) begin
            outputs_due.push_back(filter_sample(req_sample));
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_psel && csr_penable)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
   end

   // The watchdog looks at the count on the falling edge, after the rising edge has updated it.
   initial begin
      do begin
         @(negedge clock);
      end while (idle_cycles < WatchdogLimit);
      $display("watchdog: no handshake for %0d cycles", WatchdogLimit);
      $display("** svf_morph_filter: FAILED **");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Response side: runs of always-ready, coin-flip readiness, and ready with
   // occasional long stalls, switching mode when a randomly drawn run length ends.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         case (ready_mode)
            0: begin
               rsp_ready <= 1'b1;
            end
            1: begin
               rsp_ready <= 1'($urandom_range(0, 1));
            end
            default: begin
               rsp_ready <= 1'b1;
               if ($urandom_range(0, 15) == 0) begin
                  stall_left = $urandom_range(1, 24);
               end
            end
         endcase
      end
      mode_left--;
      if (mode_left == 0) begin
         ready_mode = $urandom_range(0, 2);
         mode_left  = $urandom_range(50, 400);
      end
   end

   // ------------------------------------------------------------------------
   // Request side and register access.
   // ------------------------------------------------------------------------

   // Sends one sample and returns once it has been accepted. Requests go out
   // in bursts; between bursts valid drops for a random number of cycles,
   // and some bursts follow the previous one with no gap at all.
   task automatic send_sample(input logic signed [SampleW-1:0] x);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MaxGap);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
         if (gap != 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid  <= 1'b1;
      req_sample <= x;
      do begin
         @(posedge clock);
      end while (!req_ready);
   endtask

   // Stops sending and waits until every predicted response has been taken,
   // which leaves the filter idle and safe to reprogram.
   task automatic wait_for_outputs();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outputs_due.size() != 0) @(negedge clock);
   endtask

   // Reads a register back and compares it with our copy.
   task automatic check_register(input csr_index_type idx);
      logic [DataW-1:0] want;
      case (idx)
         REG_CUTOFF_GAIN: want = DataW'(gain_q);
         REG_DAMPING:     want = DataW'(damp_q);
         REG_NORMALISER:  want = DataW'(norm_q);
         REG_MORPH:       want = DataW'(morph_q);
         default:         want = '0;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!csr_pready);
      if (csr_prdata !== want) begin
         report_error($sformatf("register %s reads %0h, expected %0h", idx.name(),
                                csr_prdata, want));
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Writes a register, mirrors the write in our copy with the register's
   // width applied, then reads it back.
   task automatic program_register(input csr_index_type idx, input logic [DataW-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!csr_pready);
      case (idx)
         REG_CUTOFF_GAIN: gain_q  = value[GainW-1:0];
         REG_DAMPING:     damp_q  = value[DampW-1:0];
         REG_NORMALISER:  norm_q  = value[NormW-1:0];
         REG_MORPH:       morph_q = value[MorphW-1:0];
         default: ;
      endcase
      check_register(idx);
   endtask

   // Programs a consistent coefficient set: gain, damping, the matching
   // normaliser, and the morph amount.
   task automatic set_filter(input longint g, input longint r2, input longint morph);
      program_register(REG_CUTOFF_GAIN, DataW'(g));
      program_register(REG_DAMPING, DataW'(r2));
      program_register(REG_NORMALISER, DataW'(norm_for(g, r2)));
      program_register(REG_MORPH, DataW'(morph));
   endtask

   // ------------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------------

   // Reset values read back, and the filter runs on them: with zero gain the
   // input passes straight to the highpass output.
   task automatic test_reset_values();
      check_register(REG_CUTOFF_GAIN);
      check_register(REG_DAMPING);
      check_register(REG_NORMALISER);
      check_register(REG_MORPH);
      send_sample(24'sh7FFFFF);
      send_sample(24'sh800000);
      send_sample(24'sd1);
      wait_for_outputs();
   endtask

   // Full-scale steps in both directions, zero and minus one, on a moderate
   // Butterworth-like setting.
   task automatic test_sample_extremes();
      set_filter(QOne / 2, 64'd23726566, 64'd16384);
      send_sample(24'sh7FFFFF);
      send_sample(24'sh7FFFFF);
      send_sample(24'sh800000);
      send_sample(24'sh800000);
      send_sample(24'sh000000);
      send_sample(24'shFFFFFF);
      wait_for_outputs();
   endtask

   // The morph blend at pure lowpass, pure bandpass, just past bandpass
   // where the second crossfade takes over, and pure highpass.
   task automatic test_morph_points();
      program_register(REG_MORPH, DataW'(0));
      send_sample(24'sh400000);
      wait_for_outputs();
      program_register(REG_MORPH, DataW'(MorphHalf));
      send_sample(24'shC00000);
      wait_for_outputs();
      program_register(REG_MORPH, DataW'(MorphHalf) + 1);
      send_sample(24'sh123456);
      wait_for_outputs();
      program_register(REG_MORPH, DataW'(MorphOne));
      send_sample(24'shABCDEF);
      wait_for_outputs();
   endtask

   task automatic test_special_cases();
      // A morph amount above one, written with every data bit set, acts as
      // pure highpass.
      program_register(REG_MORPH, 32'hFFFF_FFFF);
      send_sample(24'sh600000);
      send_sample(24'shA00000);
      wait_for_outputs();
      // A normaliser above one amplifies and drives the outputs into
      // saturation.
      program_register(REG_MORPH, DataW'(16384));
      program_register(REG_NORMALISER, DataW'((1 << NormW) - 1));
      send_sample(24'sh7FFFFF);
      send_sample(24'sh800000);
      wait_for_outputs();
      // Zero damping: an undamped resonator that only saturation bounds.
      program_register(REG_DAMPING, DataW'(0));
      program_register(REG_NORMALISER, DataW'(QOne));
      send_sample(24'sh7FFFFF);
      send_sample(24'sh7FFFFF);
      wait_for_outputs();
      // Largest gain with largest damping.
      program_register(REG_CUTOFF_GAIN, DataW'((1 << GainW) - 1));
      program_register(REG_DAMPING, DataW'((1 << DampW) - 1));
      send_sample(24'sh800000);
      send_sample(24'sh7FFFFF);
      wait_for_outputs();
   endtask

   // Random phases. The first two pin every register at its top and bottom
   // value; the rest mostly use realistic coefficient sets, with some fully
   // random ones, a zero gain and a maximum gain mixed in. Within a phase
   // the samples follow one waveform kind with occasional full-range noise.
   task automatic test_random_sweep();
      int kind;
      int hold_left;
      int level;
      int amp;
      int v;
      longint g;
      longint r2;
      longint morph;
      logic signed [SampleW-1:0] x;
      for (int phase = 0; phase < RandomPhases; phase++) begin
         wait_for_outputs();
         if (phase == 0) begin
            program_register(REG_CUTOFF_GAIN, DataW'((1 << GainW) - 1));
            program_register(REG_DAMPING, DataW'((1 << DampW) - 1));
            program_register(REG_NORMALISER, DataW'((1 << NormW) - 1));
            program_register(REG_MORPH, DataW'((1 << MorphW) - 1));
         end else if (phase == 1) begin
            program_register(REG_CUTOFF_GAIN, DataW'(0));
            program_register(REG_DAMPING, DataW'(0));
            program_register(REG_NORMALISER, DataW'(0));
            program_register(REG_MORPH, DataW'(0));
         end else begin
            case ($urandom_range(0, 9))
               0, 1: begin
                  program_register(REG_CUTOFF_GAIN, $urandom());
                  program_register(REG_DAMPING, $urandom());
                  program_register(REG_NORMALISER, $urandom());
                  program_register(REG_MORPH, $urandom());
               end
               2: begin
                  g  = 0;
                  r2 = $urandom_range(QOne, 20 * QOne);
               end
               3: begin
                  g  = (longint'(1) << GainW) - 1;
                  r2 = $urandom_range(QOne, 20 * QOne);
               end
               default: begin
                  g  = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 1 << 16)
                                                   : $urandom_range(1 << 16, 3 * QOne);
                  r2 = ($urandom_range(0, 2) == 0) ? QOne : $urandom_range(QOne, 20 * QOne);
               end
            endcase
            if (g >= 0 && r2 >= QOne) begin
               case ($urandom_range(0, 5))
                  0: morph = 0;
                  1: morph = MorphHalf;
                  2: morph = MorphOne;
                  default: morph = $urandom_range(0, MorphOne);
               endcase
               set_filter(g, r2, morph);
            end
         end
         // Clear the coefficient choice so a fully random phase does not
         // reprogram a realistic set over its own random values next time.
         g  = -1;
         r2 = 0;

         kind      = $urandom_range(0, 3);
         hold_left = 0;
         level     = 1;
         repeat (PhaseItems) begin
            case (kind)
               0: begin
                  x = SampleW'($urandom());
               end
               1: begin
                  v = int'($urandom_range(0, 4000)) - 2000;
                  x = v[SampleW-1:0];
               end
               2: begin
                  // Square wave with random amplitude and half period.
                  if (hold_left == 0) begin
                     amp       = $urandom_range(1, 8388607);
                     level     = (level > 0) ? -amp : amp;
                     hold_left = $urandom_range(1, 40);
                  end
                  hold_left--;
                  x = level[SampleW-1:0];
               end
               default: begin
                  case ($urandom_range(0, 3))
                     0: x = 24'sh7FFFFF;
                     1: x = 24'sh800000;
                     2: x = 24'sh000000;
                     default: x = 24'shFFFFFF;
                  endcase
               end
            endcase
            if ($urandom_range(0, 7) == 0) begin
               x = SampleW'($urandom());
            end
            send_sample(x);
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Test sequence.
   // ------------------------------------------------------------------------
   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_sample_extremes();
      test_morph_points();
      test_special_cases();
      test_random_sweep();

      // Let the last responses drain, then watch a little longer for any
      // response that should not be there.
      wait_for_outputs();
      repeat (TailCycles) @(negedge clock);
      if (outputs_due.size() != 0) begin
         report_error($sformatf("%0d responses never arrived", outputs_due.size()));
      end
      if (error_count == 0) begin
         $display("** svf_morph_filter: PASSED **");
      end else begin
         $display("** svf_morph_filter: FAILED **");
      end
      $finish;
   end

endmodule
